// ----- src/sqb_pkg.sv -----
// shared types, constants and sine table for the sprite quad batcher
package sqb_pkg;

    localparam int MAX_BATCHES_DEF   = 16;
    localparam int MAX_TEX_SLOTS_DEF = 32;

    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic CFG_SPRITES_PER_BATCH  = 1'b0;
    localparam logic CFG_TEXTURES_PER_BATCH = 1'b1;

    localparam logic [15:0] SPRITES_PER_BATCH_RESET  = 16'd10000;
    localparam logic [5:0]  TEXTURES_PER_BATCH_RESET = 6'd16;

    localparam int BIDX_W = 8;

    localparam logic [14:0] QSIN [17] = '{
        15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102, 15'd10394,
        15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137, 15'd15679, 15'd16069,
        15'd16305, 15'd16384
    };

    typedef struct packed {
        logic [4:0]        slot;
        logic              textured;
        logic [BIDX_W-1:0] batch;
        logic [15:0]       count;
        logic              closed;
    } spr_info_t;

    function automatic logic [14:0] sine_quarter(input logic [14:0] q);
        logic [4:0]  idx;
        logic [9:0]  frac;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [10:0] delta;
        logic [21:0] prod;
        idx  = q[14:10];
        frac = q[9:0];
        if (idx[4])
        begin
            return QSIN[16];
        end
        lo    = QSIN[idx[3:0]];
        hi    = QSIN[5'({1'b0, idx[3:0]} + 5'd1)];
        delta = 11'(hi - lo);
        prod  = 22'(delta) * 22'(frac) + 22'd512;
        return 15'(lo + 15'(prod[21:10]));
    endfunction

    function automatic logic signed [15:0] sine_of(input logic [15:0] a);
        logic [14:0] q;
        logic [14:0] v;
        q = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        v = sine_quarter(q);
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

// ----- src/sqb_batch_state.sv -----
// batch indices, per-batch sprite counts and texture slot table
module sqb_batch_state
    import sqb_pkg::*;
#(
    parameter int MAX_BATCHES       = MAX_BATCHES_DEF,
    parameter int MAX_TEXTURE_SLOTS = MAX_TEX_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [1:0]  req_type,
    input  logic [15:0] texture_id,
    input  logic [15:0] sprites_per_batch,
    input  logic [5:0]  textures_per_batch,
    output spr_info_t   info
);

    localparam int BI_W   = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
    localparam int SLOT_W = (MAX_TEXTURE_SLOTS > 1) ? $clog2(MAX_TEXTURE_SLOTS) : 1;
    localparam logic [5:0]      SLOTS_MAX = 6'(MAX_TEXTURE_SLOTS);
    localparam logic [BI_W-1:0] LAST_BATCH = BI_W'(MAX_BATCHES - 1);

    logic [BI_W-1:0]   plain_idx_reg;
    logic [BI_W-1:0]   tex_idx_reg;
    logic [15:0]       plain_cnt_reg [MAX_BATCHES];
    logic [15:0]       tex_cnt_reg [MAX_BATCHES];
    logic [15:0]       slot_id_reg [MAX_TEXTURE_SLOTS];
    logic [5:0]        siu_reg;

    logic              textured;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] slot;
    logic [5:0]        siu_after;
    logic [BI_W-1:0]   batch;
    logic [15:0]       count;
    logic [15:0]       count_new;
    logic              closed;
    logic              draw;

    always_comb
    begin
        textured = (texture_id != 16'd0);
        found    = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < MAX_TEXTURE_SLOTS; i++)
        begin
            if (!found && (6'(i) < siu_reg) && (slot_id_reg[i] == texture_id))
            begin
                found    = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
        new_slot  = (siu_reg < SLOTS_MAX) ? SLOT_W'(siu_reg) : SLOT_W'(MAX_TEXTURE_SLOTS - 1);
        slot      = found ? hit_slot : new_slot;
        siu_after = (textured && !found && (siu_reg < SLOTS_MAX)) ? 6'(siu_reg + 6'd1) : siu_reg;
        batch     = textured ? tex_idx_reg : plain_idx_reg;
        count     = textured ? tex_cnt_reg[batch] : plain_cnt_reg[batch];
        count_new = (count == 16'hFFFF) ? count : 16'(count + 16'd1);
        closed    = (count_new >= sprites_per_batch);
        if (textured)
        begin
            closed = closed || ({1'b0, siu_after} >= {1'b0, textures_per_batch})
                     || (siu_after >= SLOTS_MAX);
        end
        else
        begin
            closed = closed || (textures_per_batch == 6'd0);
        end
        info.slot     = textured ? 5'(slot) : 5'd0;
        info.textured = textured;
        info.batch    = BIDX_W'(batch);
        info.count    = count;
        info.closed   = closed;
    end

    assign draw = step && (req_type == REQ_DRAW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_idx_reg <= '0;
            tex_idx_reg   <= '0;
            siu_reg       <= '0;
            for (int i = 0; i < MAX_BATCHES; i++)
            begin
                plain_cnt_reg[i] <= '0;
                tex_cnt_reg[i]   <= '0;
            end
        end
        else if (step)
        begin
            unique case (req_type)
                REQ_DRAW:
                begin
                    if (textured)
                    begin
                        tex_cnt_reg[batch] <= count_new;
                        siu_reg <= closed ? 6'd0 : siu_after;
                        if (closed && (tex_idx_reg < LAST_BATCH))
                        begin
                            tex_idx_reg <= BI_W'(tex_idx_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        plain_cnt_reg[batch] <= count_new;
                        if (closed && (plain_idx_reg < LAST_BATCH))
                        begin
                            plain_idx_reg <= BI_W'(plain_idx_reg + 1'b1);
                        end
                    end
                end
                REQ_FLUSH:
                begin
                    siu_reg <= '0;
                    for (int i = 0; i < MAX_BATCHES; i++)
                    begin
                        plain_cnt_reg[i] <= '0;
                        tex_cnt_reg[i]   <= '0;
                    end
                end
                REQ_END:
                begin
                    plain_idx_reg <= '0;
                    tex_idx_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw && textured && !found)
        begin
            slot_id_reg[new_slot] <= texture_id;
        end
    end

endmodule

// ----- src/sprite_quad_batcher_top.sv -----
// top level of the sprite quad batcher: item pipeline and corner math
//
// Each draw item yields four vertex items, one per cycle while out_ready does
// not stall the output, and a sprite holds the corner stage until its fourth
// vertex leaves, with the next draw item waiting in the input register; flush
// and end-scene items give no result. An item passes an input register, where
// the sine lookup and all batch bookkeeping (slot match over the slot table,
// count update, batch close) happen, then a sprite register that the corner
// stage reads with four multipliers per vertex, then an output register.
// Configuration writes are taken at any time but belong to idle periods.
module sprite_quad_batcher_top
    import sqb_pkg::*;
#(
    parameter int MAX_BATCHES       = MAX_BATCHES_DEF,
    parameter int MAX_TEXTURE_SLOTS = MAX_TEX_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [23:0] pos_x0,
    input  logic signed [23:0] pos_y0,
    input  logic [22:0]        size_w,
    input  logic [22:0]        size_h,
    input  logic [31:0]        color_rgba,
    input  logic [15:0]        angle,
    input  logic [15:0]        texture_id,
    input  logic [16:0]        frame_x,
    input  logic [16:0]        frame_y,
    input  logic [16:0]        frame_w,
    input  logic [16:0]        frame_h,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] vert_x,
    output logic signed [23:0] vert_y,
    output logic [17:0]        tex_u,
    output logic [17:0]        tex_v,
    output logic [31:0]        vert_color,
    output logic [4:0]         slot_used,
    output logic               is_textured,
    output logic [3:0]         batch_number,
    output logic [17:0]        vertex_slot,
    output logic               last_of_sprite,
    output logic               batch_closed
);

    // configuration
    logic [15:0] spb_reg;
    logic [5:0]  tpb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= SPRITES_PER_BATCH_RESET;
            tpb_reg <= TEXTURES_PER_BATCH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SPRITES_PER_BATCH:  spb_reg <= cfg_data;
                CFG_TEXTURES_PER_BATCH: tpb_reg <= cfg_data[5:0];
            endcase
        end
    end

    // input register
    logic               iv_reg;
    logic [1:0]         req_reg;
    logic signed [23:0] x0_reg;
    logic signed [23:0] y0_reg;
    logic [22:0]        w_reg;
    logic [22:0]        h_reg;
    logic [31:0]        color_reg;
    logic [15:0]        angle_reg;
    logic [15:0]        tid_reg;
    logic [16:0]        fx_reg;
    logic [16:0]        fy_reg;
    logic [16:0]        fw_reg;
    logic [16:0]        fh_reg;

    // sprite register
    logic               sv_reg;
    logic [1:0]         corner_reg;
    spr_info_t          info_reg;
    logic signed [25:0] cx_reg;
    logic signed [25:0] cy_reg;
    logic [22:0]        sw_reg;
    logic [22:0]        sh_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic [17:0]        u0_reg;
    logic [17:0]        u1_reg;
    logic [17:0]        v0_reg;
    logic [17:0]        v1_reg;
    logic [31:0]        scolor_reg;

    // output register
    logic               ov_reg;
    logic signed [23:0] vx_reg;
    logic signed [23:0] vy_reg;
    logic [17:0]        u_reg;
    logic [17:0]        v_reg;
    logic [31:0]        ocolor_reg;
    logic [4:0]         oslot_reg;
    logic               otex_reg;
    logic [3:0]         obatch_reg;
    logic [17:0]        ovslot_reg;
    logic               olast_reg;
    logic               oclosed_reg;

    logic       out_load;
    logic       spr_adv;
    logic       spr_free;
    logic       step;
    logic       spr_load;
    spr_info_t  info;

    assign out_load = !ov_reg || out_ready;
    assign spr_adv  = sv_reg && out_load;
    assign spr_free = !sv_reg || (spr_adv && (corner_reg == 2'd3));
    assign step     = iv_reg && ((req_reg != REQ_DRAW) || spr_free);
    assign spr_load = step && (req_reg == REQ_DRAW);
    assign in_ready = !iv_reg || step;

    sqb_batch_state #(
        .MAX_BATCHES       (MAX_BATCHES),
        .MAX_TEXTURE_SLOTS (MAX_TEXTURE_SLOTS)
    ) u_state (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .req_type           (req_reg),
        .texture_id         (tid_reg),
        .sprites_per_batch  (spb_reg),
        .textures_per_batch (tpb_reg),
        .info               (info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg   <= req_type;
            x0_reg    <= pos_x0;
            y0_reg    <= pos_y0;
            w_reg     <= size_w;
            h_reg     <= size_h;
            color_reg <= color_rgba;
            angle_reg <= angle;
            tid_reg   <= texture_id;
            fx_reg    <= frame_x;
            fy_reg    <= frame_y;
            fw_reg    <= frame_w;
            fh_reg    <= frame_h;
        end
    end

    // per-sprite values
    logic signed [15:0] sin_w;
    logic signed [15:0] cos_w;
    logic [17:0]        usum;
    logic [17:0]        vsum;

    assign sin_w = sine_of(angle_reg);
    assign cos_w = sine_of(16'(angle_reg + 16'd16384));
    assign usum  = 18'({1'b0, fx_reg} + {1'b0, fw_reg});
    assign vsum  = 18'({1'b0, fy_reg} + {1'b0, fh_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg     <= 1'b0;
            corner_reg <= 2'd0;
        end
        else if (spr_free)
        begin
            sv_reg     <= spr_load;
            corner_reg <= 2'd0;
        end
        else if (spr_adv)
        begin
            corner_reg <= 2'(corner_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (spr_load)
        begin
            info_reg   <= info;
            cx_reg     <= 26'({x0_reg[23], x0_reg, 1'b0}) + $signed({3'b000, w_reg});
            cy_reg     <= 26'({y0_reg[23], y0_reg, 1'b0}) + $signed({3'b000, h_reg});
            sw_reg     <= w_reg;
            sh_reg     <= h_reg;
            sin_reg    <= sin_w;
            cos_reg    <= cos_w;
            u0_reg     <= {1'b0, fx_reg};
            v0_reg     <= {1'b0, fy_reg};
            u1_reg     <= (usum > 18'd131072) ? 18'd131072 : usum;
            v1_reg     <= (vsum > 18'd131072) ? 18'd131072 : vsum;
            scolor_reg <= color_reg;
        end
    end

    // corner math
    function automatic logic signed [23:0] to_q8(input logic signed [43:0] v);
        logic signed [43:0] t;
        t = (v + 44'sd16384) >>> 15;
        if (t > 44'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (t < -44'sd8388608)
        begin
            return -24'sh800000;
        end
        return t[23:0];
    endfunction

    logic signed [39:0] cw;
    logic signed [39:0] sw;
    logic signed [39:0] ch;
    logic signed [39:0] sh;
    logic signed [43:0] bx;
    logic signed [43:0] by;
    logic signed [43:0] vx_sum;
    logic signed [43:0] vy_sum;
    logic               sx_pos;
    logic               sy_pos;

    always_comb
    begin
        cw     = 40'(cos_reg * $signed({1'b0, sw_reg}));
        sw     = 40'(sin_reg * $signed({1'b0, sw_reg}));
        ch     = 40'(cos_reg * $signed({1'b0, sh_reg}));
        sh     = 40'(sin_reg * $signed({1'b0, sh_reg}));
        bx     = 44'(cx_reg) <<< 14;
        by     = 44'(cy_reg) <<< 14;
        sx_pos = corner_reg[1];
        sy_pos = ~(corner_reg[1] ^ corner_reg[0]);
        vx_sum = bx + (sx_pos ? 44'(cw) : -44'(cw)) + (sy_pos ? -44'(sh) : 44'(sh));
        vy_sum = by + (sx_pos ? 44'(sw) : -44'(sw)) + (sy_pos ? 44'(ch) : -44'(ch));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg <= sv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spr_adv)
        begin
            vx_reg      <= to_q8(vx_sum);
            vy_reg      <= to_q8(vy_sum);
            u_reg       <= sx_pos ? u1_reg : u0_reg;
            v_reg       <= sy_pos ? v1_reg : v0_reg;
            ocolor_reg  <= scolor_reg;
            oslot_reg   <= info_reg.slot;
            otex_reg    <= info_reg.textured;
            obatch_reg  <= info_reg.batch[3:0];
            ovslot_reg  <= {info_reg.count, corner_reg};
            olast_reg   <= (corner_reg == 2'd3);
            oclosed_reg <= info_reg.closed;
        end
    end

    assign out_valid      = ov_reg;
    assign vert_x         = vx_reg;
    assign vert_y         = vy_reg;
    assign tex_u          = u_reg;
    assign tex_v          = v_reg;
    assign vert_color     = ocolor_reg;
    assign slot_used      = oslot_reg;
    assign is_textured    = otex_reg;
    assign batch_number   = obatch_reg;
    assign vertex_slot    = ovslot_reg;
    assign last_of_sprite = olast_reg;
    assign batch_closed   = oclosed_reg;

endmodule
